FILE: rtl/assert_macros.svh
// assertion helper macros for the framer rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SAME(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rstn, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

FILE: rtl/crcf_pkg.sv
// shared types, constants and the crc-32c byte fold for the framer
// no dependencies
package crcf_pkg;

  localparam logic [31:0] CrcPoly  = 32'h82F6_3B78;
  localparam logic [31:0] CrcOnes  = 32'hFFFF_FFFF;
  localparam logic [7:0]  StxByte  = 8'h02;
  localparam logic [7:0]  EtxByte  = 8'h03;
  localparam logic [15:0] MaxPayloadReset = 16'd1024;

  // command queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // one classified input transaction
  typedef struct packed {
    logic        err;
    logic        hdr;
    logic        has_byte;
    logic        eop;
    logic [15:0] len;
    logic [7:0]  data;
  } crcf_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } crcf_q_status_t;

  // reflected crc-32c, one byte folded in
  function automatic logic [31:0] crcf_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/crcf_front.sv
// front end: accepts input transactions, tracks frame state, classifies into commands
// depends on crcf_pkg
module crcf_front import crcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_carries_byte,
  input  logic        in_start_of_packet,
  input  logic        in_end_of_packet,
  input  logic [15:0] in_total_length,
  input  crcf_q_status_t q_status,
  output logic        q_push,
  output crcf_cmd_t   q_cmd
);

  logic [15:0] max_payload_r;
  logic        in_packet_r, in_packet_nxt;
  logic        discarding_r, discarding_nxt;
  logic        produce;
  logic        accept;

  assign in_full = q_status.full;
  assign accept  = in_push && !q_status.full;
  assign q_push  = accept && produce;

  // classify one transaction: start, then byte, then end
  always_comb begin
    q_cmd          = '0;
    q_cmd.len      = in_total_length;
    q_cmd.data     = in_data_byte;
    produce        = 1'b0;
    in_packet_nxt  = in_packet_r;
    discarding_nxt = discarding_r;
    if (discarding_r) begin
      if (in_end_of_packet) discarding_nxt = 1'b0;
    end else begin
      if (in_start_of_packet) begin
        if (in_total_length > max_payload_r) begin
          q_cmd.err      = 1'b1;
          produce        = 1'b1;
          in_packet_nxt  = 1'b0;
          discarding_nxt = !in_end_of_packet;
        end else begin
          q_cmd.hdr     = 1'b1;
          produce       = 1'b1;
          in_packet_nxt = 1'b1;
        end
      end
      if (!q_cmd.err && in_packet_nxt) begin
        if (in_carries_byte) begin
          q_cmd.has_byte = 1'b1;
          produce        = 1'b1;
        end
        if (in_end_of_packet) begin
          q_cmd.eop     = 1'b1;
          produce       = 1'b1;
          in_packet_nxt = 1'b0;
        end
      end
    end
  end

  // frame state and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MaxPayloadReset;
      in_packet_r   <= 1'b0;
      discarding_r  <= 1'b0;
    end else begin
      if (cfg_we) max_payload_r <= cfg_data;
      if (accept) begin
        in_packet_r  <= in_packet_nxt;
        discarding_r <= discarding_nxt;
      end
    end
  end

endmodule

FILE: rtl/crcf_fifo.sv
// short command queue between front and back
// depends on crcf_pkg
module crcf_fifo import crcf_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  crcf_cmd_t      push_cmd,
  input  logic           pop,
  output crcf_cmd_t      head,
  output crcf_q_status_t status
);

  crcf_cmd_t        mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r;
  logic [QPtrW-1:0] rd_ptr_r;
  logic [QCntW-1:0] count_r;
  logic             do_push, do_pop;

  assign status.full  = (count_r == QCntW'(QDepth));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPtrW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPtrW'(1);
      if (do_push && !do_pop)      count_r <= count_r + QCntW'(1);
      else if (do_pop && !do_push) count_r <= count_r - QCntW'(1);
    end
  end

endmodule

FILE: rtl/crcf_back.sv
// back end: sequences header, payload, trailer bytes and keeps the crc registers
// depends on crcf_pkg
module crcf_back import crcf_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  crcf_cmd_t      head,
  input  crcf_q_status_t q_status,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_byte,
  output logic           out_status,
  output logic           out_last_of_run
);

  typedef enum logic [3:0] {
    PH_STX, PH_LEN_LO, PH_LEN_HI, PH_HC0, PH_HC1, PH_HC2, PH_HC3,
    PH_DATA, PH_PC0, PH_PC1, PH_PC2, PH_PC3, PH_ETX, PH_ERR
  } phase_t;

  phase_t      phase_r, phase_nxt, cur;
  logic        busy_r, busy_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        status_r, status_nxt;
  logic        last_r;
  logic        done;
  logic        advance, go;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] hcrc_r, hcrc_nxt;
  logic [31:0] hcrc_inv, crc_inv;

  assign advance   = !out_valid_r || out_pop;
  assign go        = advance && !q_status.empty;
  assign q_pop     = go && done;
  assign out_empty = !out_valid_r;
  assign out_byte        = byte_r;
  assign out_status      = status_r;
  assign out_last_of_run = last_r;
  assign hcrc_inv  = ~hcrc_r;
  assign crc_inv   = ~crc_r;

  // the stored phase while busy, else the first phase of a fresh command
  always_comb begin
    if (busy_r)         cur = phase_r;
    else if (head.err)  cur = PH_ERR;
    else if (head.hdr)  cur = PH_STX;
    else if (head.has_byte) cur = PH_DATA;
    else                cur = PH_PC0;
  end

  // byte, crc update and next phase for the current step
  always_comb begin
    byte_nxt   = 8'd0;
    status_nxt = 1'b0;
    done       = 1'b0;
    phase_nxt  = cur;
    crc_nxt    = crc_r;
    hcrc_nxt   = hcrc_r;
    unique case (cur)
      PH_STX: begin
        byte_nxt  = StxByte;
        hcrc_nxt  = crcf_fold(CrcOnes, StxByte);
        crc_nxt   = CrcOnes;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        byte_nxt  = head.len[7:0];
        hcrc_nxt  = crcf_fold(hcrc_r, head.len[7:0]);
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        byte_nxt  = head.len[15:8];
        hcrc_nxt  = crcf_fold(hcrc_r, head.len[15:8]);
        phase_nxt = PH_HC0;
      end
      PH_HC0: begin byte_nxt = hcrc_inv[7:0];   phase_nxt = PH_HC1; end
      PH_HC1: begin byte_nxt = hcrc_inv[15:8];  phase_nxt = PH_HC2; end
      PH_HC2: begin byte_nxt = hcrc_inv[23:16]; phase_nxt = PH_HC3; end
      PH_HC3: begin
        byte_nxt = hcrc_inv[31:24];
        if (head.has_byte) phase_nxt = PH_DATA;
        else if (head.eop) phase_nxt = PH_PC0;
        else               done      = 1'b1;
      end
      PH_DATA: begin
        byte_nxt = head.data;
        crc_nxt  = crcf_fold(crc_r, head.data);
        if (head.eop) phase_nxt = PH_PC0;
        else          done      = 1'b1;
      end
      PH_PC0: begin byte_nxt = crc_inv[7:0];   phase_nxt = PH_PC1; end
      PH_PC1: begin byte_nxt = crc_inv[15:8];  phase_nxt = PH_PC2; end
      PH_PC2: begin byte_nxt = crc_inv[23:16]; phase_nxt = PH_PC3; end
      PH_PC3: begin byte_nxt = crc_inv[31:24]; phase_nxt = PH_ETX; end
      PH_ETX: begin
        byte_nxt = EtxByte;
        crc_nxt  = CrcOnes;
        done     = 1'b1;
      end
      PH_ERR: begin
        status_nxt = 1'b1;
        crc_nxt    = CrcOnes;
        done       = 1'b1;
      end
      default: done = 1'b1;
    endcase
    busy_nxt      = go ? !done : busy_r;
    out_valid_nxt = advance ? !q_status.empty : out_valid_r;
  end

  // sequencer state, crc registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_STX;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= CrcOnes;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (go) begin
        phase_r  <= phase_nxt;
        crc_r    <= crc_nxt;
        hcrc_r   <= hcrc_nxt;
        byte_r   <= byte_nxt;
        status_r <= status_nxt;
        last_r   <= done;
      end
    end
  end

endmodule

FILE: rtl/crc32c_packet_framer_core.sv
// top level of the stx/etx packet framer with crc-32c
// depends on crcf_pkg, crcf_front, crcf_fifo, crcf_back and assert_macros.svh

// A transaction is taken on every cycle while in_full is low; in_full rises only
// when the four-entry command queue is full. The back end delivers one framed
// byte per cycle through a single output register while out_pop drains it and a
// command is queued; a transaction yields as many output bytes as it causes: one
// for a plain payload byte, seven for a header, five for a trailer, up to thirteen
// when start, byte and end come together, and one for a length error. Transactions
// that cause no byte never reach the queue. The header crc is folded one byte per
// cycle as the header bytes leave, so no extra latency follows a start mark.
`include "assert_macros.svh"

module crc32c_packet_framer_core import crcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_carries_byte,
  input  logic        in_start_of_packet,
  input  logic        in_end_of_packet,
  input  logic [15:0] in_total_length,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_status,
  output logic        out_last_of_run
);

  crcf_cmd_t      push_cmd, head;
  crcf_q_status_t q_status;
  logic           q_push, q_pop;

  // classify transactions
  crcf_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_data, .in_push, .in_full,
    .in_data_byte, .in_carries_byte, .in_start_of_packet, .in_end_of_packet,
    .in_total_length, .q_status, .q_push, .q_cmd(push_cmd)
  );

  // command queue
  crcf_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .push_cmd, .pop(q_pop), .head, .status(q_status)
  );

  // byte sequencer
  crcf_back u_back (
    .clk, .rst_n, .head, .q_status, .q_pop, .out_empty, .out_pop,
    .out_byte, .out_status, .out_last_of_run
  );

  // checks
  `ASSERT_SAME(a_no_overflow, clk, rst_n, q_push, !q_status.full, "push into full queue")
  `ASSERT_SAME(a_no_underflow, clk, rst_n, q_pop, !q_status.empty, "pop from empty queue")
  `ASSERT_SAME(a_err_shape, clk, rst_n, !out_empty && out_status, (out_byte == 8'd0) && out_last_of_run, "error result malformed")
  `ASSERT_NEXT(a_pop_fills, clk, rst_n, q_pop, !out_empty, "popped command gave no result")

endmodule
